@@ src/jsu_pkg.sv @@
// Shared types and constants for the JSON string unescape block.
`default_nettype none

package jsu_pkg;

  // Result kinds carried on the master tuser field.
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Most results that one input byte can cause.
  localparam int unsigned MAX_RESULTS = 4;

  // Results of one input byte, handed from the decoder to the output stage.
  typedef struct packed {
    logic [2:0]                        count;
    logic [MAX_RESULTS-1:0][7:0]       data;
    logic [MAX_RESULTS-1:0][1:0]       kind;
  } jsu_bundle_t;

endpackage

`default_nettype wire

@@ src/jsu_decode.sv @@
// Escape decoder: holds the string state and turns one byte into its results.
`default_nettype none

module jsu_decode
  import jsu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  in_byte,
  input  wire logic        text_ends,
  output jsu_bundle_t      bundle
);

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX   = 2'd2
  } mode_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_U     = 8'h75;

  mode_t       mode;
  logic [1:0]  hex_count;
  logic [15:0] code_accum;
  logic        hex_ok;

  mode_t       mode_next;
  logic [1:0]  hex_count_next;
  logic [15:0] code_accum_next;
  logic        hex_ok_next;

  logic [2:0][7:0] dbyte;
  logic [1:0]      ndata;
  logic            closed;
  logic            nib_ok;
  logic [3:0]      nib;
  logic [15:0]     acc_shift;
  logic            ok_shift;

  // Hex digit value, with a flag for a valid digit.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Next state and the decoded data bytes of this input byte.
  always_comb begin
    mode_next       = mode;
    hex_count_next  = hex_count;
    code_accum_next = code_accum;
    hex_ok_next     = hex_ok;
    dbyte           = '0;
    ndata           = 2'd0;
    closed          = 1'b0;
    {nib_ok, nib}   = hex_nibble(in_byte);
    acc_shift       = {code_accum[11:0], nib};
    ok_shift        = hex_ok & nib_ok;

    unique case (mode)
      MODE_ESC: begin
        mode_next = MODE_PLAIN;
        ndata     = 2'd1;
        case (in_byte)
          CH_N: dbyte[0] = 8'h0A;
          CH_T: dbyte[0] = 8'h09;
          CH_R: dbyte[0] = 8'h0D;
          CH_B: dbyte[0] = 8'h08;
          CH_F: dbyte[0] = 8'h0C;
          CH_U: begin
            mode_next       = MODE_HEX;
            hex_count_next  = 2'd0;
            code_accum_next = 16'd0;
            hex_ok_next     = 1'b1;
            dbyte[0]        = CH_QMARK;
            ndata           = text_ends ? 2'd1 : 2'd0;
          end
          default: dbyte[0] = in_byte;
        endcase
      end
      MODE_HEX: begin
        code_accum_next = acc_shift;
        hex_ok_next     = ok_shift;
        if (hex_count == 2'd3) begin
          mode_next       = MODE_PLAIN;
          hex_count_next  = 2'd0;
          code_accum_next = 16'd0;
          hex_ok_next     = 1'b1;
          if (!ok_shift || (acc_shift >= 16'hD800 && acc_shift <= 16'hDFFF)) begin
            dbyte[0] = CH_QMARK;
            ndata    = 2'd1;
          end else if (acc_shift < 16'h0080) begin
            dbyte[0] = acc_shift[7:0];
            ndata    = 2'd1;
          end else if (acc_shift < 16'h0800) begin
            dbyte[0] = {3'b110, acc_shift[10:6]};
            dbyte[1] = {2'b10, acc_shift[5:0]};
            ndata    = 2'd2;
          end else begin
            dbyte[0] = {4'b1110, acc_shift[15:12]};
            dbyte[1] = {2'b10, acc_shift[11:6]};
            dbyte[2] = {2'b10, acc_shift[5:0]};
            ndata    = 2'd3;
          end
        end else begin
          hex_count_next = hex_count + 2'd1;
          dbyte[0]       = CH_QMARK;
          ndata          = text_ends ? 2'd1 : 2'd0;
        end
      end
      default: begin
        if (in_byte == CH_QUOTE) begin
          closed = 1'b1;
        end else if (in_byte == CH_BSL) begin
          dbyte[0] = CH_BSL;
          if (text_ends) begin
            ndata = 2'd1;
          end else begin
            mode_next = MODE_ESC;
          end
        end else begin
          dbyte[0] = in_byte;
          ndata    = 2'd1;
        end
      end
    endcase

    // A closing quote or the end of the text returns to the idle state.
    if (closed || text_ends) begin
      mode_next       = MODE_PLAIN;
      hex_count_next  = 2'd0;
      code_accum_next = 16'd0;
      hex_ok_next     = 1'b1;
    end
  end

  // Assemble the result list: an ok marker alone, or data bytes then, when the text ends, an error marker.
  always_comb begin
    bundle = '0;
    if (closed) begin
      bundle.count   = 3'd1;
      bundle.kind[0] = KIND_OK;
    end else begin
      for (int i = 0; i < 3; i++) begin
        bundle.data[i] = dbyte[i];
        bundle.kind[i] = KIND_DATA;
      end
      bundle.count = {1'b0, ndata};
      if (text_ends) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
          if (i[1:0] == ndata) begin
            bundle.data[i] = 8'h00;
            bundle.kind[i] = KIND_ERR;
          end
        end
        bundle.count = {1'b0, ndata} + 3'd1;
      end
    end
  end

  // State registers, updated on each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_PLAIN;
      hex_count  <= 2'd0;
      code_accum <= 16'd0;
      hex_ok     <= 1'b1;
    end else if (accept) begin
      mode       <= mode_next;
      hex_count  <= hex_count_next;
      code_accum <= code_accum_next;
      hex_ok     <= hex_ok_next;
    end
  end

endmodule

`default_nettype wire

@@ src/jsu_emit.sv @@
// Output stage: holds the results of one byte and sends them one per cycle while the receiver is ready.
`default_nettype none

module jsu_emit
  import jsu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  jsu_bundle_t      bundle,
  output logic             load_ready,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);

  logic [2:0]                  left;
  logic [1:0]                  idx;
  logic [MAX_RESULTS-1:0][7:0] data;
  logic [MAX_RESULTS-1:0][1:0] kind;
  logic                        take;

  // The holding register frees up once its final result is taken.
  assign m_tvalid   = (left != 3'd0);
  assign take       = m_tvalid && m_tready;
  assign load_ready = (left == 3'd0) || ((left == 3'd1) && m_tready);

  assign m_tdata = data[idx];
  assign m_tuser = kind[idx];
  assign m_tlast = (left == 3'd1);

  // Control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= 3'd0;
      idx  <= 2'd0;
    end else if (load) begin
      left <= bundle.count;
      idx  <= 2'd0;
    end else if (take) begin
      left <= left - 3'd1;
      idx  <= idx + 2'd1;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      data <= bundle.data;
      kind <= bundle.kind;
    end
  end

endmodule

`default_nettype wire

@@ src/json_string_unescape.sv @@
// Top level of the JSON string unescape block.
//
// Slave channel: one raw byte of a string body per transaction, the bytes
// after the opening quote; s_tlast marks the last byte of the available text.
// Master channel: decoded bytes, one per transaction. m_tuser gives the kind
// (0 data byte, 1 string closed ok, 2 unterminated string error) and m_tlast
// marks the final result caused by one input byte.
//
// An input byte is decoded in the cycle it is accepted and its results
// (none to four) appear on the master side from the next cycle, one per
// cycle while the receiver is ready, and a byte with at most one result is
// taken every cycle too; a byte with more results holds the slave side until
// the single output register stage that drains them has sent the last one.
//
// Reset returns the decoder to plain characters and drops pending results.
// When the receiver stalls, the current result holds and the slave side
// accepts a new byte only as the last pending result is taken.
`default_nettype none

module json_string_unescape
  import jsu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // in_byte
  input  wire logic        s_tlast,   // text_ends
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // out_byte
  output logic [1:0]       m_tuser,   // item_kind
  output logic             m_tlast    // last_of_run
);

  jsu_bundle_t bundle;
  logic        accept;

  assign accept = s_tvalid && s_tready;

  // Escape decoding and state.
  jsu_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (s_tdata),
    .text_ends (s_tlast),
    .bundle    (bundle)
  );

  // Result holding register and serializer.
  jsu_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .bundle     (bundle),
    .load_ready (s_tready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

@@ tb/json_string_unescape_tb.sv @@
// Self-checking testbench for the JSON string unescape block.
`default_nettype none

module json_string_unescape_tb;
  import jsu_pkg::*;

  // One raw body byte waiting to be sent, with its end-of-text flag.
  typedef struct {
    logic [7:0] data;
    logic       ends;
    logic       drain_first;  // hold this byte until every decoded result is back
  } body_byte_t;

  // One decoded result as it should appear on the master side.
  typedef struct {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } decoded_t;

  typedef enum logic [1:0] {
    PLAIN      = 2'd0,
    ESCAPED    = 2'd1,
    HEX_DIGITS = 2'd2
  } unesc_mode_t;

  localparam int unsigned RANDOM_BYTES = 500;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned SETTLE       = 20;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'd0;
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  json_string_unescape dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // in_byte
    .s_tlast  (s_tlast),   // text_ends
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // out_byte
    .m_tuser  (m_tuser),   // item_kind
    .m_tlast  (m_tlast)    // last_of_run
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  body_byte_t  body_q[$];
  decoded_t    decoded_q[$];
  decoded_t    run_q[$];
  int unsigned bytes_taken = 0;
  int unsigned mismatches  = 0;
  bit          in_took     = 1'b0;
  bit          drain_next  = 1'b0;

  // Decoder state mirrored by the testbench.
  unesc_mode_t mode;
  logic [1:0]  digit_count;
  logic [15:0] code_point;
  logic        digits_ok;

  // Hex digit value; valid is low for any byte that is not a hex digit.
  function automatic logic [3:0] hex_value(input logic [7:0] c, output logic valid);
    valid = 1'b1;
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
    valid = 1'b0;
    return 4'd0;
  endfunction

  function automatic void clear_decoder();
    mode        = PLAIN;
    digit_count = 2'd0;
    code_point  = 16'd0;
    digits_ok   = 1'b1;
  endfunction

  function automatic void emit(input logic [7:0] b, input logic [1:0] k);
    decoded_t r;
    r.data = b;
    r.kind = k;
    r.last = 1'b0;
    run_q.push_back(r);
  endfunction

  // UTF-8 encoding of one code point; surrogates become a question mark.
  function automatic void emit_utf8(input logic [15:0] v);
    if (v < 16'h0080) begin
      emit(v[7:0], KIND_DATA);
    end else if (v < 16'h0800) begin
      emit({3'b110, v[10:6]}, KIND_DATA);
      emit({2'b10, v[5:0]}, KIND_DATA);
    end else if (v >= 16'hD800 && v <= 16'hDFFF) begin
      emit("?", KIND_DATA);
    end else begin
      emit({4'hE, v[15:12]}, KIND_DATA);
      emit({2'b10, v[11:6]}, KIND_DATA);
      emit({2'b10, v[5:0]}, KIND_DATA);
    end
  endfunction

  // Works out the results of one accepted body byte and queues them.
  function automatic void unescape_byte(input logic [7:0] c, input logic ends);
    logic       closed;
    logic       valid;
    logic [3:0] nib;
    closed = 1'b0;
    run_q.delete();
    case (mode)
      ESCAPED: begin
        mode = PLAIN;
        case (c)
          "n": emit(8'h0A, KIND_DATA);
          "t": emit(8'h09, KIND_DATA);
          "r": emit(8'h0D, KIND_DATA);
          "b": emit(8'h08, KIND_DATA);
          "f": emit(8'h0C, KIND_DATA);
          "u": begin
            mode        = HEX_DIGITS;
            digit_count = 2'd0;
            code_point  = 16'd0;
            digits_ok   = 1'b1;
            if (ends) emit("?", KIND_DATA);
          end
          default: emit(c, KIND_DATA);
        endcase
      end
      HEX_DIGITS: begin
        nib = hex_value(c, valid);
        if (!valid) digits_ok = 1'b0;
        code_point = {code_point[11:0], nib};
        if (digit_count == 2'd3) begin
          if (digits_ok) emit_utf8(code_point);
          else emit("?", KIND_DATA);
          clear_decoder();
        end else begin
          digit_count = digit_count + 2'd1;
          if (ends) emit("?", KIND_DATA);
        end
      end
      default: begin
        // Plain characters; the unused mode value behaves the same way.
        if (c == "\"") begin
          emit(8'd0, KIND_OK);
          closed = 1'b1;
        end else if (c == "\\") begin
          if (ends) emit("\\", KIND_DATA);
          else mode = ESCAPED;
        end else begin
          emit(c, KIND_DATA);
        end
      end
    endcase
    if (closed) begin
      clear_decoder();
    end else if (ends) begin
      emit(8'd0, KIND_ERR);
      clear_decoder();
    end
    if (run_q.size() != 0) run_q[run_q.size() - 1].last = 1'b1;
    foreach (run_q[i]) decoded_q.push_back(run_q[i]);
  endfunction

  // Stimulus building.
  task automatic add(input logic [7:0] b, input logic ends);
    body_byte_t it;
    it.data        = b;
    it.ends        = ends;
    it.drain_first = drain_next;
    drain_next     = 1'b0;
    body_q.push_back(it);
  endtask

  task automatic add_text(input string s, input logic ends_on_last);
    for (int i = 0; i < s.len(); i++) add(s[i], ends_on_last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'("0" + n);
    return 8'((upper ? "A" : "a") + n - 10);
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    logic       valid;
    do begin
      b = 8'($urandom_range(0, 255));
      void'(hex_value(b, valid));
    end while (valid);
    return b;
  endfunction

  // A \u escape with ndig digits; one digit may be spoiled, and the text may end on
  // the last byte added.
  task automatic add_unicode(input logic [15:0] v, input int bad_at, input int ndig,
                             input logic ends);
    logic [7:0] c;
    add("\\", 1'b0);
    add("u", ends && ndig == 0);
    for (int i = 0; i < ndig; i++) begin
      c = hex_char(v[15 - 4*i -: 4], $urandom_range(0, 1));
      if (i == bad_at) c = non_hex_byte();
      add(c, ends && (i == ndig - 1));
    end
  endtask

  function automatic logic [15:0] pick_code_point();
    logic [15:0] edges[10] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800,
                               16'hD7FF, 16'hD800, 16'hDFFF, 16'hE000, 16'hFFFF};
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(16'h0000, 16'h007F));
      1: return 16'($urandom_range(16'h0080, 16'h07FF));
      2: return 16'($urandom_range(16'hD800, 16'hDFFF));
      3: return 16'($urandom_range(16'h0800, 16'hFFFF));
      default: return edges[$urandom_range(0, 9)];
    endcase
  endfunction

  // One random token: mostly well-formed string pieces, some broken text and noise.
  task automatic add_random_token();
    int unsigned pick;
    logic [7:0]  b;
    logic [7:0]  esc_chars[8] = '{"n", "t", "r", "b", "f", "\"", "\\", "/"};
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      do b = 8'($urandom_range(0, 255)); while (b == "\"" || b == "\\");
      add(b, 1'b0);
    end else if (pick < 50) begin
      add("\\", 1'b0);
      if ($urandom_range(0, 3) == 0) begin
        do b = 8'($urandom_range(0, 255)); while (b == "u");
      end else begin
        b = esc_chars[$urandom_range(0, 7)];
      end
      add(b, 1'b0);
    end else if (pick < 68) begin
      add_unicode(pick_code_point(), -1, 4, 1'b0);
    end else if (pick < 73) begin
      add_unicode(pick_code_point(), $urandom_range(0, 3), 4, 1'b0);
    end else if (pick < 83) begin
      add("\"", $urandom_range(0, 7) == 0);
    end else if (pick < 93) begin
      // Text that runs out somewhere inside the string.
      case ($urandom_range(0, 4))
        0: add(8'($urandom_range(0, 255)), 1'b1);
        1: add("\\", 1'b1);
        2: add_unicode(pick_code_point(), -1, $urandom_range(0, 3), 1'b1);
        3: add_unicode(pick_code_point(), -1, 4, 1'b1);
        default: begin
          add("\\", 1'b0);
          add(8'($urandom_range(0, 255)), 1'b1);
        end
      endcase
    end else begin
      add(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end
  endtask

  // Stimulus, reset and end of run.
  initial begin
    int unsigned directed;
    bit          mid_drain;
    mid_drain = 1'b0;
    clear_decoder();
    add(8'h00, 1'b0);
    add(8'hFF, 1'b0);
    add_text("\\n", 1'b0);
    add_text("\\\"", 1'b0);
    add_text("\\u20AC", 1'b0);
    add_text("\\uDFFF", 1'b0);
    add_text("\\u00\"0", 1'b0);
    add_text("\"", 1'b0);
    add_text("\"", 1'b1);
    add_text("\\", 1'b1);
    add_text("\\u1", 1'b1);
    add_text("z", 1'b1);
    directed = body_q.size();
    while (body_q.size() < directed + RANDOM_BYTES) begin
      // One guaranteed pause halfway through, plus a few random ones.
      if (!mid_drain && body_q.size() >= directed + RANDOM_BYTES / 2) begin
        drain_next = 1'b1;
        mid_drain  = 1'b1;
      end else if ($urandom_range(0, 99) == 0) begin
        drain_next = 1'b1;
      end
      add_random_token();
    end
    directed = body_q.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (bytes_taken < directed) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(negedge clk) begin : feed
    logic offer;
    offer = 1'b0;
    if (!rst && (!s_tvalid || in_took)) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (body_q.size() != 0 &&
                   !(body_q[0].drain_first && decoded_q.size() != 0)) begin
        offer = 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (offer) begin
        s_tvalid <= 1'b1;
        s_tdata  <= body_q[0].data;
        s_tlast  <= body_q[0].ends;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern changes every so often, plus one long hold-off.
  int unsigned stall_style = 0;
  int unsigned style_left  = 50;
  int unsigned hold_left   = 0;
  bit          long_done   = 1'b0;

  always @(negedge clk) begin : drain
    logic ready;
    ready = 1'b1;
    if (!long_done && bytes_taken >= 120) begin
      long_done = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 3);
      style_left  = $urandom_range(20, 80);
    end else begin
      style_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      ready = 1'b0;
    end else begin
      case (stall_style)
        0: ready = 1'b1;
        1: ready = 1'($urandom_range(0, 1));
        2: ready = $urandom_range(0, 7) != 0;
        default: ready = $urandom_range(0, 3) == 0;
      endcase
    end
    m_tready <= ready;
  end

  // Result check against the oldest expectation, then prediction of the new byte.
  always @(posedge clk) begin : track
    decoded_t want;
    in_took = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result data=%02h kind=%0d last=%0d",
                   $time, m_tdata, m_tuser, m_tlast);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          if (m_tdata !== want.data || m_tuser !== want.kind || m_tlast !== want.last) begin
            $display("%0t: expected data=%02h kind=%0d last=%0d, got data=%02h kind=%0d last=%0d",
                     $time, want.data, want.kind, want.last, m_tdata, m_tuser, m_tlast);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        in_took = 1'b1;
        unescape_byte(s_tdata, s_tlast);
        void'(body_q.pop_front());
        bytes_taken++;
      end
    end
  end

  // Watchdog on cycles without any transaction.
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

`default_nettype wire
